[rtl/core/kebt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kebt_pkg
// Shared types and byte constants of the key event to terminal byte encoder.
// ----------------------------------------------------------------------------
package kebt_pkg;

    // Longest byte sequence of one event, and the default event queue depth.
    localparam int unsigned SeqMax      = 7;
    localparam int unsigned SeqIdxW     = $clog2(SeqMax);
    localparam int unsigned SeqLenW     = $clog2(SeqMax + 1);
    localparam int unsigned QueueDepthD = 2;

    // Event kinds.
    localparam logic [1:0] KIND_NAMED = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;

    // Named key codes.
    localparam logic [3:0] KEY_ESC   = 4'd0;
    localparam logic [3:0] KEY_ENTER = 4'd1;
    localparam logic [3:0] KEY_TAB   = 4'd2;
    localparam logic [3:0] KEY_BKSP  = 4'd3;
    localparam logic [3:0] KEY_UP    = 4'd4;
    localparam logic [3:0] KEY_DOWN  = 4'd5;
    localparam logic [3:0] KEY_RIGHT = 4'd6;
    localparam logic [3:0] KEY_LEFT  = 4'd7;
    localparam logic [3:0] KEY_HOME  = 4'd8;
    localparam logic [3:0] KEY_END   = 4'd9;
    localparam logic [3:0] KEY_INS   = 4'd10;
    localparam logic [3:0] KEY_DEL   = 4'd11;
    localparam logic [3:0] KEY_PGUP  = 4'd12;
    localparam logic [3:0] KEY_PGDN  = 4'd13;

    // Editing command codes.
    localparam logic [3:0] CMD_WORD_LEFT  = 4'd0;
    localparam logic [3:0] CMD_WORD_RIGHT = 4'd1;
    localparam logic [3:0] CMD_ROW_START  = 4'd2;
    localparam logic [3:0] CMD_ROW_END    = 4'd3;
    localparam logic [3:0] CMD_PAGE_UP    = 4'd4;
    localparam logic [3:0] CMD_PAGE_DOWN  = 4'd5;

    // Modifier mask bits.
    localparam int unsigned MOD_SHIFT_BIT = 0;
    localparam int unsigned MOD_ALT_BIT   = 1;
    localparam int unsigned MOD_CTRL_BIT  = 2;

    // Byte values.
    localparam logic [7:0] B_ESC   = 8'h1b;
    localparam logic [7:0] B_CR    = 8'h0d;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] B_DEL   = 8'h7f;
    localparam logic [7:0] B_LBRK  = 8'h5b;
    localparam logic [7:0] B_TILDE = 8'h7e;
    localparam logic [7:0] B_SEMI  = 8'h3b;
    localparam logic [7:0] B_ZERO  = 8'h30;
    localparam logic [7:0] B_ONE   = 8'h31;
    localparam logic [7:0] B_TWO   = 8'h32;
    localparam logic [7:0] B_THREE = 8'h33;
    localparam logic [7:0] B_FIVE  = 8'h35;
    localparam logic [7:0] B_SIX   = 8'h36;
    localparam logic [7:0] B_UP_A  = 8'h41;
    localparam logic [7:0] B_F     = 8'h46;
    localparam logic [7:0] B_H     = 8'h48;
    localparam logic [7:0] B_Z     = 8'h5a;
    localparam logic [7:0] B_LC_B  = 8'h62;
    localparam logic [7:0] B_LC_F  = 8'h66;
    localparam logic [7:0] B_SOH   = 8'h01;
    localparam logic [7:0] B_ENQ   = 8'h05;
    localparam logic [7:0] B_CONT  = 8'h80;
    localparam logic [7:0] B_LEAD2 = 8'hc0;
    localparam logic [7:0] B_LEAD3 = 8'he0;
    localparam logic [7:0] B_LEAD4 = 8'hf0;

    // One event's byte sequence as it travels through the queue.
    typedef struct packed {
        logic [SeqMax-1:0][7:0] bytes;
        logic [SeqLenW-1:0]     len;
    } t_seq;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

[rtl/core/kebt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kebt_front
// Classifies one key or command event and builds its complete byte sequence.
// ----------------------------------------------------------------------------
module kebt_front (
    input  logic [1:0]   i_kind,
    input  logic         i_is_release,
    input  logic [3:0]   i_key_code,
    input  logic [3:0]   i_command_code,
    input  logic [20:0]  i_codepoint,
    input  logic         i_has_shifted,
    input  logic [20:0]  i_shifted_codepoint,
    input  logic [5:0]   i_modifier_mask,
    output kebt_pkg::t_seq o_seq
);
    import kebt_pkg::*;

    logic [20:0] w_cp;
    logic [20:0] w_fold;
    logic [6:0]  w_param;
    logic [3:0]  w_tens;
    logic [3:0]  w_units;
    logic [7:0]  w_fin;
    logic [3:0][7:0] w_utf;
    logic [2:0]  w_utf_len;
    t_seq        w_seq;

    assign w_cp = i_has_shifted ? i_shifted_codepoint : i_codepoint;

    // xterm modifier parameter and its two decimal digits (value at most 64).
    assign w_param = {1'b0, i_modifier_mask} + 7'd1;
    always_comb begin
        if (w_param >= 7'd60) begin
            w_tens = 4'd6;
        end else if (w_param >= 7'd50) begin
            w_tens = 4'd5;
        end else if (w_param >= 7'd40) begin
            w_tens = 4'd4;
        end else if (w_param >= 7'd30) begin
            w_tens = 4'd3;
        end else if (w_param >= 7'd20) begin
            w_tens = 4'd2;
        end else if (w_param >= 7'd10) begin
            w_tens = 4'd1;
        end else begin
            w_tens = 4'd0;
        end
    end
    assign w_units = 4'(w_param - ({3'd0, w_tens} * 7'd10));

    assign w_fin = B_UP_A + {6'd0, i_key_code[1:0]};

    // Control folds lower case letters onto upper case.
    assign w_fold = (w_cp >= 21'h61 && w_cp <= 21'h7a) ? (w_cp - 21'h20) : w_cp;

    always_comb begin
        w_utf = '0;
        if (w_cp <= 21'h7f) begin
            w_utf[0]  = w_cp[7:0];
            w_utf_len = 3'd1;
        end else if (w_cp <= 21'h7ff) begin
            w_utf[0]  = B_LEAD2 | {3'd0, w_cp[10:6]};
            w_utf[1]  = B_CONT | {2'd0, w_cp[5:0]};
            w_utf_len = 3'd2;
        end else if (w_cp <= 21'hffff) begin
            w_utf[0]  = B_LEAD3 | {4'd0, w_cp[15:12]};
            w_utf[1]  = B_CONT | {2'd0, w_cp[11:6]};
            w_utf[2]  = B_CONT | {2'd0, w_cp[5:0]};
            w_utf_len = 3'd3;
        end else begin
            w_utf[0]  = B_LEAD4 | {5'd0, w_cp[20:18]};
            w_utf[1]  = B_CONT | {2'd0, w_cp[17:12]};
            w_utf[2]  = B_CONT | {2'd0, w_cp[11:6]};
            w_utf[3]  = B_CONT | {2'd0, w_cp[5:0]};
            w_utf_len = 3'd4;
        end
    end

    always_comb begin
        w_seq = '0;
        case (i_kind)
            KIND_NAMED: begin
                if (!i_is_release) begin
                    case (i_key_code)
                        KEY_ESC: begin
                            w_seq.bytes[0] = B_ESC;
                            w_seq.len      = SeqLenW'(1);
                        end
                        KEY_ENTER: begin
                            w_seq.bytes[0] = B_CR;
                            w_seq.len      = SeqLenW'(1);
                        end
                        KEY_TAB: begin
                            if (i_modifier_mask[MOD_SHIFT_BIT]) begin
                                w_seq.bytes[0] = B_ESC;
                                w_seq.bytes[1] = B_LBRK;
                                w_seq.bytes[2] = B_Z;
                                w_seq.len      = SeqLenW'(3);
                            end else begin
                                w_seq.bytes[0] = B_TAB;
                                w_seq.len      = SeqLenW'(1);
                            end
                        end
                        KEY_BKSP: begin
                            w_seq.bytes[0] = B_DEL;
                            w_seq.len      = SeqLenW'(1);
                        end
                        KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT: begin
                            w_seq.bytes[0] = B_ESC;
                            w_seq.bytes[1] = B_LBRK;
                            if (w_param == 7'd1) begin
                                w_seq.bytes[2] = w_fin;
                                w_seq.len      = SeqLenW'(3);
                            end else begin
                                w_seq.bytes[2] = B_ONE;
                                w_seq.bytes[3] = B_SEMI;
                                if (w_tens != 4'd0) begin
                                    w_seq.bytes[4] = B_ZERO | {4'd0, w_tens};
                                    w_seq.bytes[5] = B_ZERO | {4'd0, w_units};
                                    w_seq.bytes[6] = w_fin;
                                    w_seq.len      = SeqLenW'(7);
                                end else begin
                                    w_seq.bytes[4] = B_ZERO | {4'd0, w_units};
                                    w_seq.bytes[5] = w_fin;
                                    w_seq.len      = SeqLenW'(6);
                                end
                            end
                        end
                        KEY_HOME, KEY_END: begin
                            w_seq.bytes[0] = B_ESC;
                            w_seq.bytes[1] = B_LBRK;
                            w_seq.bytes[2] = (i_key_code == KEY_HOME) ? B_H : B_F;
                            w_seq.len      = SeqLenW'(3);
                        end
                        KEY_INS, KEY_DEL, KEY_PGUP, KEY_PGDN: begin
                            w_seq.bytes[0] = B_ESC;
                            w_seq.bytes[1] = B_LBRK;
                            case (i_key_code)
                                KEY_INS:  w_seq.bytes[2] = B_TWO;
                                KEY_DEL:  w_seq.bytes[2] = B_THREE;
                                KEY_PGUP: w_seq.bytes[2] = B_FIVE;
                                default:  w_seq.bytes[2] = B_SIX;
                            endcase
                            w_seq.bytes[3] = B_TILDE;
                            w_seq.len      = SeqLenW'(4);
                        end
                        default: begin
                            w_seq.len = '0;
                        end
                    endcase
                end
            end
            KIND_CHAR: begin
                if (!i_is_release) begin
                    if (i_modifier_mask[MOD_CTRL_BIT]) begin
                        // Control gives a control code or nothing; alt is ignored.
                        if (w_fold >= 21'h40 && w_fold <= 21'h5f) begin
                            w_seq.bytes[0] = {3'd0, w_fold[4:0]};
                            w_seq.len      = SeqLenW'(1);
                        end else if (w_fold == 21'h3f) begin
                            w_seq.bytes[0] = B_DEL;
                            w_seq.len      = SeqLenW'(1);
                        end
                    end else if (i_modifier_mask[MOD_ALT_BIT]) begin
                        w_seq.bytes[0] = B_ESC;
                        w_seq.bytes[1] = w_utf[0];
                        w_seq.bytes[2] = w_utf[1];
                        w_seq.bytes[3] = w_utf[2];
                        w_seq.bytes[4] = w_utf[3];
                        w_seq.len      = SeqLenW'(w_utf_len) + SeqLenW'(1);
                    end else begin
                        w_seq.bytes[0] = w_utf[0];
                        w_seq.bytes[1] = w_utf[1];
                        w_seq.bytes[2] = w_utf[2];
                        w_seq.bytes[3] = w_utf[3];
                        w_seq.len      = SeqLenW'(w_utf_len);
                    end
                end
            end
            KIND_CMD: begin
                case (i_command_code)
                    CMD_WORD_LEFT, CMD_WORD_RIGHT: begin
                        w_seq.bytes[0] = B_ESC;
                        w_seq.bytes[1] = (i_command_code == CMD_WORD_LEFT) ? B_LC_B : B_LC_F;
                        w_seq.len      = SeqLenW'(2);
                    end
                    CMD_ROW_START: begin
                        w_seq.bytes[0] = B_SOH;
                        w_seq.len      = SeqLenW'(1);
                    end
                    CMD_ROW_END: begin
                        w_seq.bytes[0] = B_ENQ;
                        w_seq.len      = SeqLenW'(1);
                    end
                    CMD_PAGE_UP, CMD_PAGE_DOWN: begin
                        w_seq.bytes[0] = B_ESC;
                        w_seq.bytes[1] = B_LBRK;
                        w_seq.bytes[2] = (i_command_code == CMD_PAGE_UP) ? B_FIVE : B_SIX;
                        w_seq.bytes[3] = B_TILDE;
                        w_seq.len      = SeqLenW'(4);
                    end
                    default: begin
                        w_seq.len = '0;
                    end
                endcase
            end
            default: begin
                w_seq.len = '0;
            end
        endcase
    end

    assign o_seq = w_seq;

endmodule

[rtl/core/kebt_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kebt_fifo
// Small queue of byte sequences between the classifier and the serializer.
// ----------------------------------------------------------------------------
module kebt_fifo #(
    parameter int unsigned Depth = kebt_pkg::QueueDepthD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  kebt_pkg::t_seq       i_wr_data,
    input  logic                 i_rd,
    output kebt_pkg::t_seq       o_rd_data,
    output kebt_pkg::t_fifo_status o_status
);
    import kebt_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_seq            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_do_wr;
    logic            w_do_rd;

    assign o_status.full  = (r_count == CntW'(Depth));
    assign o_status.empty = (r_count == '0);
    assign w_do_wr = i_wr && !o_status.full;
    assign w_do_rd = i_rd && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_do_rd && !w_do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

[rtl/core/kebt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kebt_back
// Serializes queued byte sequences into a registered byte-wide output.
// ----------------------------------------------------------------------------
module kebt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  kebt_pkg::t_seq i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_last,
    output logic           o_busy
);
    import kebt_pkg::*;

    t_seq               r_cur;
    logic               r_cur_valid;
    logic [SeqIdxW-1:0] r_idx;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               w_emit;
    logic               w_is_last;
    logic               w_load;

    assign w_is_last = (SeqLenW'(r_idx) == r_cur.len - SeqLenW'(1));
    assign w_emit    = r_cur_valid && (!r_out_valid || i_pop);
    assign w_load    = !i_q_empty && (!r_cur_valid || (w_emit && w_is_last));
    assign o_q_pop   = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (w_load) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (w_emit) begin
                r_cur_valid <= !w_is_last;
                r_idx       <= r_idx + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_q_data;
        end
        if (w_emit) begin
            r_out_byte <= r_cur.bytes[r_idx];
            r_out_last <= w_is_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_busy     = r_cur_valid;

endmodule

[rtl/core/key_event_to_terminal_bytes_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_to_terminal_bytes_unit
// Encodes key and editing-command events into xterm-style terminal bytes.
// ----------------------------------------------------------------------------
// One event enters per cycle while full is low; the front classifies it and
// writes its whole byte sequence (up to seven bytes) into a queue of
// QueueDepth entries, and events that produce no bytes are dropped there.
// The back drains the queue at one byte per cycle while each byte is popped as
// it appears; the serializer is what sets the sustained rate. The first byte of
// an event passes from the queue through the serializer's sequence register
// into the output register, and last marks the final byte of each event.
module key_event_to_terminal_bytes_unit #(
    parameter int unsigned QueueDepth = kebt_pkg::QueueDepthD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic        i_is_release,
    input  logic [3:0]  i_key_code,
    input  logic [3:0]  i_command_code,
    input  logic [20:0] i_codepoint,
    input  logic        i_has_shifted,
    input  logic [20:0] i_shifted_codepoint,
    input  logic [5:0]  i_modifier_mask,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import kebt_pkg::*;

    t_seq         w_seq;
    t_seq         w_q_data;
    t_fifo_status w_q_status;
    logic         w_q_wr;
    logic         w_q_pop;
    logic         w_back_busy;

    kebt_front u_front (
        .i_kind              (i_kind),
        .i_is_release        (i_is_release),
        .i_key_code          (i_key_code),
        .i_command_code      (i_command_code),
        .i_codepoint         (i_codepoint),
        .i_has_shifted       (i_has_shifted),
        .i_shifted_codepoint (i_shifted_codepoint),
        .i_modifier_mask     (i_modifier_mask),
        .o_seq               (w_seq)
    );

    assign full   = w_q_status.full;
    assign w_q_wr = push && !w_q_status.full && (w_seq.len != '0);

    kebt_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_seq),
        .i_rd      (w_q_pop),
        .o_rd_data (w_q_data),
        .o_status  (w_q_status)
    );

    kebt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_status.empty),
        .i_q_data   (w_q_data),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_busy     (w_back_busy)
    );

`ifndef SYNTHESIS
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("event queue reports full and empty at once");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_status.empty)
        else $error("serializer took a sequence from an empty queue");

    a_escape_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_kind == KIND_NAMED && !i_is_release && i_key_code == KEY_ESC)
        |=> (!w_q_status.empty || w_back_busy || !empty))
        else $error("escape key transfer left no pending output");
`endif

endmodule

[sim/kebt_byte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kebt_byte_checker
// Watches both sides of the key event encoder, works out the terminal bytes
// of every transferred event and compares them with the bytes popped.
// ----------------------------------------------------------------------------
module kebt_byte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_kind,
    input  logic        i_is_release,
    input  logic [3:0]  i_key_code,
    input  logic [3:0]  i_command_code,
    input  logic [20:0] i_codepoint,
    input  logic        i_has_shifted,
    input  logic [20:0] i_shifted_codepoint,
    input  logic [5:0]  i_modifier_mask,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_outstanding
);
    import kebt_pkg::*;

    localparam logic [7:0]  NO_TAIL  = 8'h00;
    localparam logic [20:0] CH_LC_A  = 21'h61;
    localparam logic [20:0] CH_LC_Z  = 21'h7a;
    localparam logic [20:0] CH_AT    = 21'h40;
    localparam logic [20:0] CH_US    = 21'h5f;
    localparam logic [20:0] CH_QMARK = 21'h3f;
    localparam logic [20:0] CASE_GAP = 21'h20;
    localparam logic [20:0] CP_MAX1  = 21'h00007f;
    localparam logic [20:0] CP_MAX2  = 21'h0007ff;
    localparam logic [20:0] CP_MAX3  = 21'h00ffff;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_term_byte;

    t_term_byte term_bytes_due[$];
    logic [7:0] event_seq[$];

    function automatic void append_byte(input logic [7:0] b);
        event_seq = {event_seq, b};
    endfunction

    function automatic void emit_csi(input logic [7:0] tail0, input logic [7:0] tail1);
        append_byte(B_ESC);
        append_byte(B_LBRK);
        append_byte(tail0);
        if (tail1 != NO_TAIL) begin
            append_byte(tail1);
        end
    endfunction

    // Builds the byte sequence of one event in event_seq.
    function automatic void encode_key_event(
        input logic [1:0]  kind,
        input logic        rel,
        input logic [3:0]  key,
        input logic [3:0]  cmd,
        input logic [20:0] cp,
        input logic        hs,
        input logic [20:0] scp,
        input logic [5:0]  mods
    );
        int unsigned param;
        logic [20:0] ch;
        logic [7:0]  digit;
        event_seq.delete();
        ch = hs ? scp : cp;
        case (kind)
            KIND_NAMED: begin
                if (!rel) begin
                    case (key)
                        KEY_ESC:   append_byte(B_ESC);
                        KEY_ENTER: append_byte(B_CR);
                        KEY_TAB: begin
                            if (mods[MOD_SHIFT_BIT]) begin
                                emit_csi(B_Z, NO_TAIL);
                            end else begin
                                append_byte(B_TAB);
                            end
                        end
                        KEY_BKSP:  append_byte(B_DEL);
                        KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT: begin
                            // The xterm modifier parameter is only written when it is not 1.
                            param = 1 + mods;
                            append_byte(B_ESC);
                            append_byte(B_LBRK);
                            if (param != 1) begin
                                append_byte(B_ONE);
                                append_byte(B_SEMI);
                                if (param >= 10) begin
                                    digit = B_ZERO + 8'(param / 10);
                                    append_byte(digit);
                                end
                                digit = B_ZERO + 8'(param % 10);
                                append_byte(digit);
                            end
                            digit = B_UP_A + {4'd0, key - KEY_UP};
                            append_byte(digit);
                        end
                        KEY_HOME:  emit_csi(B_H, NO_TAIL);
                        KEY_END:   emit_csi(B_F, NO_TAIL);
                        KEY_INS:   emit_csi(B_TWO, B_TILDE);
                        KEY_DEL:   emit_csi(B_THREE, B_TILDE);
                        KEY_PGUP:  emit_csi(B_FIVE, B_TILDE);
                        KEY_PGDN:  emit_csi(B_SIX, B_TILDE);
                        default: ;
                    endcase
                end
            end
            KIND_CHAR: begin
                if (!rel) begin
                    if (mods[MOD_CTRL_BIT]) begin
                        // Control wins over alt; letters fold to upper case first.
                        if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
                            ch = ch - CASE_GAP;
                        end
                        if (ch >= CH_AT && ch <= CH_US) begin
                            append_byte({3'b000, ch[4:0]});
                        end else if (ch == CH_QMARK) begin
                            append_byte(B_DEL);
                        end
                    end else begin
                        if (mods[MOD_ALT_BIT]) begin
                            append_byte(B_ESC);
                        end
                        // UTF-8 by value range only, so values past Unicode still
                        // take the four-byte form.
                        if (ch <= CP_MAX1) begin
                            append_byte(ch[7:0]);
                        end else if (ch <= CP_MAX2) begin
                            append_byte(B_LEAD2 | {3'b000, ch[10:6]});
                            append_byte(B_CONT | {2'b00, ch[5:0]});
                        end else if (ch <= CP_MAX3) begin
                            append_byte(B_LEAD3 | {4'b0000, ch[15:12]});
                            append_byte(B_CONT | {2'b00, ch[11:6]});
                            append_byte(B_CONT | {2'b00, ch[5:0]});
                        end else begin
                            append_byte(B_LEAD4 | {5'b00000, ch[20:18]});
                            append_byte(B_CONT | {2'b00, ch[17:12]});
                            append_byte(B_CONT | {2'b00, ch[11:6]});
                            append_byte(B_CONT | {2'b00, ch[5:0]});
                        end
                    end
                end
            end
            KIND_CMD: begin
                case (cmd)
                    CMD_WORD_LEFT: begin
                        append_byte(B_ESC);
                        append_byte(B_LC_B);
                    end
                    CMD_WORD_RIGHT: begin
                        append_byte(B_ESC);
                        append_byte(B_LC_F);
                    end
                    CMD_ROW_START: append_byte(B_SOH);
                    CMD_ROW_END:   append_byte(B_ENQ);
                    CMD_PAGE_UP:   emit_csi(B_FIVE, B_TILDE);
                    CMD_PAGE_DOWN: emit_csi(B_SIX, B_TILDE);
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    task automatic record_mismatch(input t_term_byte want, input logic have_want);
        if (o_mismatches < REPORT_LIMIT) begin
            if (have_want) begin
                $display("%0t: byte mismatch: expected byte %h last %b, got byte %h last %b",
                         $realtime, want.data, want.last, i_out_byte, i_last);
            end else begin
                $display("%0t: unexpected byte %h last %b with nothing outstanding",
                         $realtime, i_out_byte, i_last);
            end
        end
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        t_term_byte head;
        t_term_byte entry;
        if (!i_rst_n) begin
            term_bytes_due.delete();
            o_mismatches = 0;
            o_outstanding <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (term_bytes_due.size() == 0) begin
                    head = '0;
                    record_mismatch(head, 1'b0);
                end else begin
                    head = term_bytes_due.pop_front();
                    if (head.data !== i_out_byte || head.last !== i_last) begin
                        record_mismatch(head, 1'b1);
                    end
                end
            end
            if (i_push && !i_full) begin
                encode_key_event(i_kind, i_is_release, i_key_code, i_command_code,
                                 i_codepoint, i_has_shifted, i_shifted_codepoint,
                                 i_modifier_mask);
                for (int k = 0; k < event_seq.size(); k++) begin
                    entry.data = event_seq[k];
                    entry.last = (k == event_seq.size() - 1);
                    term_bytes_due = {term_bytes_due, entry};
                end
            end
            o_outstanding <= term_bytes_due.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the key event to terminal byte encoder.
// Sends a directed set of key, character and command events, then random
// events in bursts while the byte side stalls on its own pattern; a checker
// beside the block predicts and compares every byte popped.
// ----------------------------------------------------------------------------
module tb;
    import kebt_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [3:0] KEY_MODIFIER = 4'd14;
    localparam logic [3:0] KEY_OTHER    = 4'd15;
    localparam logic [3:0] CMD_UNUSED   = 4'd15;
    localparam int RANDOM_EVENTS = 320;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = '0;
    logic        i_is_release = 1'b0;
    logic [3:0]  i_key_code = '0;
    logic [3:0]  i_command_code = '0;
    logic [20:0] i_codepoint = '0;
    logic        i_has_shifted = 1'b0;
    logic [20:0] i_shifted_codepoint = '0;
    logic [5:0]  i_modifier_mask = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    logic timed_out = 1'b0;

    int drain_mode = 0;
    int drain_left = 0;
    int unsigned drain_tick = 0;

    key_event_to_terminal_bytes_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_kind              (i_kind),
        .i_is_release        (i_is_release),
        .i_key_code          (i_key_code),
        .i_command_code      (i_command_code),
        .i_codepoint         (i_codepoint),
        .i_has_shifted       (i_has_shifted),
        .i_shifted_codepoint (i_shifted_codepoint),
        .i_modifier_mask     (i_modifier_mask),
        .empty               (empty),
        .pop                 (pop),
        .o_out_byte          (o_out_byte),
        .o_last              (o_last)
    );

    kebt_byte_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_kind              (i_kind),
        .i_is_release        (i_is_release),
        .i_key_code          (i_key_code),
        .i_command_code      (i_command_code),
        .i_codepoint         (i_codepoint),
        .i_has_shifted       (i_has_shifted),
        .i_shifted_codepoint (i_shifted_codepoint),
        .i_modifier_mask     (i_modifier_mask),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_out_byte          (o_out_byte),
        .i_last              (o_last),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The byte side switches between stretches of steady popping, random
    // popping, a fixed one-in-four pattern and sparse random popping.
    always @(negedge i_clk) begin
        drain_tick <= drain_tick + 1;
        if (drain_left == 0) begin
            drain_mode <= $urandom_range(0, 3);
            drain_left <= $urandom_range(20, 80);
        end else begin
            drain_left <= drain_left - 1;
        end
        case (drain_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (drain_tick % 4 == 0);
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one event at a falling edge and holds it until it is transferred.
    task automatic put_event(
        input logic [1:0]  kind,
        input logic        rel,
        input logic [3:0]  key,
        input logic [3:0]  cmd,
        input logic [20:0] cp,
        input logic        hs,
        input logic [20:0] scp,
        input logic [5:0]  mods
    );
        i_kind              <= kind;
        i_is_release        <= rel;
        i_key_code          <= key;
        i_command_code      <= cmd;
        i_codepoint         <= cp;
        i_has_shifted       <= hs;
        i_shifted_codepoint <= scp;
        i_modifier_mask     <= mods;
        push                <= 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic logic [20:0] pick_codepoint();
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0, 1, 2: cp = 21'($urandom_range(0, 127));
            3:       cp = 21'($urandom_range(8'h3f, 8'h7a));
            4:       cp = 21'($urandom_range(21'h80, 21'h7ff));
            5:       cp = 21'($urandom_range(21'h800, 21'hffff));
            6, 7:    cp = 21'($urandom_range(21'h10000, 21'h10ffff));
            8:       cp = 21'($urandom);
            default: cp = 21'($urandom_range(8'h61, 8'h7a));
        endcase
        return cp;
    endfunction

    task automatic random_event();
        logic [1:0] kind;
        logic [3:0] cmd;
        logic [5:0] mods;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            kind = KIND_NAMED;
        end else if (pick < 16) begin
            kind = KIND_CHAR;
        end else if (pick < 19) begin
            kind = KIND_CMD;
        end else begin
            kind = KIND_UNUSED;
        end
        if ($urandom_range(0, 4) != 0) begin
            cmd = 4'($urandom_range(0, 5));
        end else begin
            cmd = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 3))
            0:       mods = '0;
            1:       mods = 6'd1 << $urandom_range(0, 5);
            default: mods = 6'($urandom_range(0, 63));
        endcase
        put_event(kind, $urandom_range(0, 7) == 0, 4'($urandom_range(0, 15)), cmd,
                  pick_codepoint(), 1'($urandom_range(0, 1)), pick_codepoint(), mods);
    endtask

    initial begin
        int burst_left;
        fork
            begin
                repeat (6) @(posedge i_clk);
                @(negedge i_clk);
                i_rst_n <= 1'b1;
                @(negedge i_clk);

                // Named keys, including backtab and one- and two-digit cursor parameters.
                put_event(KIND_NAMED, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h1fffff, 1'b1,
                          21'h1fffff, 6'h00);
                put_event(KIND_NAMED, 1'b0, KEY_ENTER, CMD_UNUSED, 21'h0, 1'b0, 21'h0, 6'h3f);
                put_event(KIND_NAMED, 1'b0, KEY_TAB, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h3e);
                put_event(KIND_NAMED, 1'b0, KEY_TAB, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h3f);
                put_event(KIND_NAMED, 1'b0, KEY_BKSP, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h04);
                put_event(KIND_NAMED, 1'b0, KEY_UP, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h00);
                put_event(KIND_NAMED, 1'b0, KEY_DOWN, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h3f);
                put_event(KIND_NAMED, 1'b0, KEY_RIGHT, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h08);
                put_event(KIND_NAMED, 1'b0, KEY_LEFT, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h09);
                put_event(KIND_NAMED, 1'b0, KEY_HOME, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h07);
                put_event(KIND_NAMED, 1'b0, KEY_INS, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h00);
                put_event(KIND_NAMED, 1'b0, KEY_PGDN, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h00);
                put_event(KIND_NAMED, 1'b0, KEY_MODIFIER, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0,
                          6'h01);
                put_event(KIND_NAMED, 1'b0, KEY_OTHER, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h00);
                put_event(KIND_NAMED, 1'b1, KEY_UP, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h05);

                // Character keys: control codes, alt prefix, the two-, three- and four-byte
                // UTF-8 forms, a value past Unicode and a release.
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h61, 1'b0, 21'h1fffff,
                          6'h04);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h3f, 1'b0, 21'h0, 6'h06);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h31, 1'b0, 21'h0, 6'h04);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h41, 1'b1, 21'h10ffff,
                          6'h02);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h7ff, 1'b0, 21'h0, 6'h00);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'hd800, 1'b0, 21'h0, 6'h01);
                put_event(KIND_CHAR, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h1fffff, 1'b0, 21'h0,
                          6'h00);
                put_event(KIND_CHAR, 1'b1, KEY_ESC, CMD_WORD_LEFT, 21'h61, 1'b0, 21'h0, 6'h00);
                put_event(KIND_UNUSED, 1'b0, KEY_ESC, CMD_WORD_LEFT, 21'h61, 1'b0, 21'h0,
                          6'h00);

                // Commands; the release flag has no effect on them.
                put_event(KIND_CMD, 1'b1, KEY_ESC, CMD_WORD_LEFT, 21'h0, 1'b0, 21'h0, 6'h00);
                for (int c = CMD_WORD_RIGHT; c <= CMD_PAGE_DOWN; c++) begin
                    put_event(KIND_CMD, 1'b0, KEY_ESC, 4'(c), 21'h0, 1'b0, 21'h0, 6'h00);
                end
                put_event(KIND_CMD, 1'b0, KEY_ESC, CMD_UNUSED, 21'h0, 1'b0, 21'h0, 6'h00);

                burst_left = 0;
                for (int n = 0; n < RANDOM_EVENTS; n++) begin
                    if (n == RANDOM_EVENTS / 2) begin
                        // Let the byte side drain completely before going on.
                        push <= 1'b0;
                        wait (outstanding == 0);
                        @(negedge i_clk);
                    end else if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        if ($urandom_range(0, 3) != 0) begin
                            idle_for($urandom_range(1, 8));
                        end
                    end
                    burst_left--;
                    random_event();
                end

                push <= 1'b0;
                wait (outstanding == 0);
                repeat (TAIL_CYCLES) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
